/* design/m4ci_pkg.sv */
`default_nettype none
package m4ci_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int ELEM_WIDTH_DEF = 32;
    localparam int N_ELEM         = 16;
    localparam int IDX_W          = 4;
    localparam int VALUE_W        = 32;
    localparam int CHUNK_W        = 32;
    localparam int CHUNK_IDX_W    = 2;
    localparam int N_TERM         = 6;
    localparam int TERM_W         = 3;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_INVERT = 1'b1;

    typedef struct packed {
        logic               action;
        logic [IDX_W-1:0]   element_index;
        logic [VALUE_W-1:0] element_value;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0]   out_index;
        logic [VALUE_W-1:0] out_value;
        logic               singular;
        logic               last_element;
    } result_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_START,
        OP_LATCH_X,
        OP_MUL_XY,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_ACC_HI,
        OP_COF_WR,
        OP_M_LATCH,
        OP_DET_MUL,
        OP_DET_ACC,
        OP_DET_CHK,
        OP_DIV_LD,
        OP_DIV_STEP,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t                 op;
        logic [IDX_W-1:0]       mat_addr;
        logic [IDX_W-1:0]       cof_addr;
        logic                   first_term;
        logic                   negate;
        logic [CHUNK_IDX_W-1:0] chunk;
        logic [IDX_W-1:0]       emit_index;
    } dp_cmd_t;

    typedef struct packed {
        logic det_zero;
    } dp_status_t;

    function automatic int chunk_count(int ew);
        return (3 * ew + 2 + CHUNK_W - 1) / CHUNK_W;
    endfunction

    // column of the 3x3 minor used by one slot of one permutation term
    function automatic logic [1:0] perm_col(logic [TERM_W-1:0] term, logic [1:0] slot);
        logic [5:0] p;
        unique case (term)
            3'd0:    p = {2'd2, 2'd1, 2'd0};
            3'd1:    p = {2'd0, 2'd2, 2'd1};
            3'd2:    p = {2'd1, 2'd0, 2'd2};
            3'd3:    p = {2'd1, 2'd2, 2'd0};
            3'd4:    p = {2'd2, 2'd0, 2'd1};
            3'd5:    p = {2'd0, 2'd1, 2'd2};
            default: p = {2'd2, 2'd1, 2'd0};
        endcase
        return p[slot*2 +: 2];
    endfunction

    // cofactor (r, c) takes the minor without row c and column r
    function automatic logic [IDX_W-1:0] minor_addr(logic [IDX_W-1:0] cof,
                                                    logic [TERM_W-1:0] term,
                                                    logic [1:0] slot);
        logic [1:0] r;
        logic [1:0] c;
        logic [1:0] row;
        logic [1:0] j;
        logic [1:0] col;
        r   = cof[3:2];
        c   = cof[1:0];
        row = slot + {1'b0, (slot >= c)};
        j   = perm_col(term, slot);
        col = j + {1'b0, (j >= r)};
        return {row, col};
    endfunction

endpackage
`default_nettype wire

/* design/m4ci_ram.sv */
`default_nettype none
module m4ci_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* design/m4ci_dp.sv */
`default_nettype none
module m4ci_dp import m4ci_pkg::*; #(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire item_t   item,
    input  wire dp_cmd_t cmd,
    output dp_status_t   status,
    output result_t      result
);

    localparam int EW      = ELEM_WIDTH;
    localparam int PROD_W  = 2 * EW;
    localparam int COF_W   = 3 * EW + 2;
    localparam int DET_W   = 4 * EW + 3;
    localparam int DIV_W   = DET_W + EW + 1;
    localparam int Q_W     = EW + 1;
    localparam int MUL_W   = CHUNK_W + 1;
    localparam int MULP_W  = 2 * MUL_W;
    localparam int N_CHUNK = chunk_count(EW);
    localparam int EXT_W   = N_CHUNK * CHUNK_W;
    localparam logic [Q_W-1:0] NEG_LIM = Q_W'(1) << (EW - 1);
    localparam logic [Q_W-1:0] POS_LIM = NEG_LIM - Q_W'(1);

    logic [EW-1:0]    mat_rd;
    logic [COF_W-1:0] cof_rd;
    logic [N_ELEM-1:0] valid_reg;
    logic              mat_vld_reg;

    logic signed [EW-1:0]     mat_val;
    logic signed [EW-1:0]     x_reg;
    logic signed [EW-1:0]     z_reg;
    logic signed [EW-1:0]     m_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [MULP_W-1:0] mul_reg;
    logic signed [COF_W-1:0]  acc_reg;
    logic signed [DET_W-1:0]  det_reg;
    logic [DET_W-1:0]         det_mag_reg;
    logic                     det_neg_reg;
    logic                     det_zero_reg;
    logic [DIV_W-1:0]         rem_reg;
    logic [DIV_W-1:0]         dsh_reg;
    logic [Q_W-1:0]           q_reg;
    logic                     qneg_reg;
    result_t                  out_reg;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [MULP_W-1:0] mul_out;
    logic signed [EXT_W-1:0]  acc_ext;
    logic [CHUNK_W-1:0]       chunk_bits;
    logic signed [MUL_W-1:0]  chunk_sel;
    logic signed [COF_W-1:0]  term_lo;
    logic signed [COF_W-1:0]  term_sel;
    logic signed [COF_W-1:0]  addend;
    logic signed [COF_W-1:0]  cof_s;
    logic [COF_W-1:0]         cof_mag;
    logic                     rem_ge;
    logic [Q_W-1:0]           q_lim;
    logic [Q_W-1:0]           q_clamp;
    logic [EW-1:0]            q_val;
    logic signed [EW-1:0]     q_res;

    m4ci_ram #(.WIDTH(EW), .DEPTH(N_ELEM)) u_mat_ram (
        .clk   (clk),
        .we    (cmd.op == OP_LOAD),
        .waddr (item.element_index),
        .wdata (item.element_value[EW-1:0]),
        .raddr (cmd.mat_addr),
        .rdata (mat_rd)
    );

    m4ci_ram #(.WIDTH(COF_W), .DEPTH(N_ELEM)) u_cof_ram (
        .clk   (clk),
        .we    (cmd.op == OP_COF_WR),
        .waddr (cmd.cof_addr),
        .wdata (acc_reg),
        .raddr (cmd.cof_addr),
        .rdata (cof_rd)
    );

    assign mat_val = mat_vld_reg ? $signed(mat_rd) : '0;

    assign acc_ext    = EXT_W'(acc_reg);
    assign chunk_bits = acc_ext[cmd.chunk*CHUNK_W +: CHUNK_W];
    assign chunk_sel  = (cmd.chunk == CHUNK_IDX_W'(N_CHUNK - 1))
                      ? $signed({chunk_bits[CHUNK_W-1], chunk_bits})
                      : $signed({1'b0, chunk_bits});

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_MUL_XY:
            begin
                mul_a = MUL_W'(x_reg);
                mul_b = MUL_W'(mat_val);
            end
            OP_MUL_LO:
            begin
                mul_a = $signed({1'b0, prod_reg[CHUNK_W-1:0]});
                mul_b = MUL_W'(mat_val);
            end
            OP_MUL_HI:
            begin
                mul_a = MUL_W'($signed(prod_reg[PROD_W-1:CHUNK_W]));
                mul_b = MUL_W'(z_reg);
            end
            OP_DET_MUL:
            begin
                mul_a = chunk_sel;
                mul_b = MUL_W'(m_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_out  = mul_a * mul_b;
    assign term_lo  = COF_W'(mul_reg);
    assign term_sel = (cmd.op == OP_ACC_HI) ? (term_lo <<< CHUNK_W) : term_lo;
    assign addend   = cmd.negate ? -term_sel : term_sel;

    assign cof_s   = $signed(cof_rd);
    assign cof_mag = cof_s[COF_W-1] ? COF_W'(-cof_s) : COF_W'(cof_s);
    assign rem_ge  = (rem_reg >= dsh_reg);

    assign q_lim   = qneg_reg ? NEG_LIM : POS_LIM;
    assign q_clamp = (q_reg > q_lim) ? q_lim : q_reg;
    assign q_val   = q_clamp[EW-1:0];
    assign q_res   = qneg_reg ? -$signed(q_val) : $signed(q_val);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.op == OP_LOAD)
        begin
            valid_reg[item.element_index] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        mat_vld_reg <= valid_reg[cmd.mat_addr];
        unique case (cmd.op)
            OP_START:
            begin
                det_reg <= '0;
            end
            OP_LATCH_X:
            begin
                x_reg <= mat_val;
                if (cmd.first_term)
                begin
                    acc_reg <= '0;
                end
            end
            OP_MUL_XY:
            begin
                prod_reg <= PROD_W'(mul_out);
            end
            OP_MUL_LO:
            begin
                z_reg   <= mat_val;
                mul_reg <= mul_out;
            end
            OP_MUL_HI:
            begin
                acc_reg <= acc_reg + addend;
                mul_reg <= mul_out;
            end
            OP_ACC_HI:
            begin
                acc_reg <= acc_reg + addend;
            end
            OP_M_LATCH:
            begin
                m_reg <= mat_val;
            end
            OP_DET_MUL:
            begin
                mul_reg <= mul_out;
            end
            OP_DET_ACC:
            begin
                det_reg <= det_reg + (DET_W'(mul_reg) <<< (CHUNK_W * cmd.chunk));
            end
            OP_DET_CHK:
            begin
                det_zero_reg <= (det_reg == '0);
                det_neg_reg  <= det_reg[DET_W-1];
                det_mag_reg  <= det_reg[DET_W-1] ? DET_W'(-det_reg) : DET_W'(det_reg);
            end
            OP_DIV_LD:
            begin
                rem_reg  <= DIV_W'(cof_mag) << (2 * FRAC_BITS);
                dsh_reg  <= DIV_W'(det_mag_reg) << EW;
                q_reg    <= '0;
                qneg_reg <= cof_s[COF_W-1] ^ det_neg_reg;
            end
            OP_DIV_STEP:
            begin
                if (rem_ge)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                q_reg   <= {q_reg[Q_W-2:0], rem_ge};
                dsh_reg <= dsh_reg >> 1;
            end
            OP_EMIT:
            begin
                out_reg.out_index    <= cmd.emit_index;
                out_reg.singular     <= det_zero_reg;
                out_reg.last_element <= (cmd.emit_index == IDX_W'(N_ELEM - 1));
                out_reg.out_value    <= det_zero_reg ? VALUE_W'(mat_val) : VALUE_W'(q_res);
            end
            default:
            begin
            end
        endcase
    end

    assign status.det_zero = det_zero_reg;
    assign result          = out_reg;

endmodule
`default_nettype wire

/* design/m4ci_ctrl.sv */
`default_nettype none
module m4ci_ctrl import m4ci_pkg::*; #(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire item_t      item,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd,
    output logic            busy,
    output logic            result_strobe
);

    localparam int N_CHUNK = chunk_count(ELEM_WIDTH);
    localparam int STEP_W  = $clog2(ELEM_WIDTH + 1);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_T_AX,
        ST_T_AY,
        ST_T_AZ,
        ST_T_M1,
        ST_T_M2,
        ST_T_M3,
        ST_C_WR,
        ST_D_LD,
        ST_D_MUL,
        ST_D_ACC,
        ST_D_CHK,
        ST_E_SEL,
        ST_S_RD,
        ST_S_OUT,
        ST_V_RD,
        ST_V_LD,
        ST_V_IT,
        ST_V_OUT
    } state_t;

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       cof_reg, cof_next;
    logic [TERM_W-1:0]      term_reg, term_next;
    logic [CHUNK_IDX_W-1:0] chunk_reg, chunk_next;
    logic [IDX_W-1:0]       emit_reg, emit_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   busy_reg;
    logic                   strobe_reg;

    logic last_cof;
    logic last_emit;
    logic term_neg;

    assign last_cof  = (cof_reg == IDX_W'(N_ELEM - 1));
    assign last_emit = (emit_reg == IDX_W'(N_ELEM - 1));
    assign term_neg  = (term_reg >= TERM_W'(N_TERM / 2)) ^ cof_reg[2] ^ cof_reg[0];

    always_comb
    begin
        state_next     = state_reg;
        cof_next       = cof_reg;
        term_next      = term_reg;
        chunk_next     = chunk_reg;
        emit_next      = emit_reg;
        step_next      = step_reg;
        cmd.op         = OP_NONE;
        cmd.mat_addr   = '0;
        cmd.cof_addr   = cof_reg;
        cmd.first_term = (term_reg == '0);
        cmd.negate     = term_neg;
        cmd.chunk      = chunk_reg;
        cmd.emit_index = emit_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (item.action == ACT_INVERT)
                    begin
                        cmd.op     = OP_START;
                        cof_next   = '0;
                        term_next  = '0;
                        state_next = ST_T_AX;
                    end
                    else
                    begin
                        cmd.op = OP_LOAD;
                    end
                end
            end
            ST_T_AX:
            begin
                cmd.mat_addr = minor_addr(cof_reg, term_reg, 2'd0);
                state_next   = ST_T_AY;
            end
            ST_T_AY:
            begin
                cmd.mat_addr = minor_addr(cof_reg, term_reg, 2'd1);
                cmd.op       = OP_LATCH_X;
                state_next   = ST_T_AZ;
            end
            ST_T_AZ:
            begin
                cmd.mat_addr = minor_addr(cof_reg, term_reg, 2'd2);
                cmd.op       = OP_MUL_XY;
                state_next   = ST_T_M1;
            end
            ST_T_M1:
            begin
                cmd.op     = OP_MUL_LO;
                state_next = ST_T_M2;
            end
            ST_T_M2:
            begin
                cmd.op     = OP_MUL_HI;
                state_next = ST_T_M3;
            end
            ST_T_M3:
            begin
                cmd.op = OP_ACC_HI;
                if (term_reg == TERM_W'(N_TERM - 1))
                begin
                    state_next = ST_C_WR;
                end
                else
                begin
                    term_next  = term_reg + TERM_W'(1);
                    state_next = ST_T_AX;
                end
            end
            ST_C_WR:
            begin
                cmd.op       = OP_COF_WR;
                cmd.mat_addr = IDX_W'(cof_reg[3:2]);
                if (cof_reg[1:0] == 2'd0)
                begin
                    chunk_next = '0;
                    state_next = ST_D_LD;
                end
                else if (last_cof)
                begin
                    state_next = ST_D_CHK;
                end
                else
                begin
                    cof_next   = cof_reg + IDX_W'(1);
                    term_next  = '0;
                    state_next = ST_T_AX;
                end
            end
            ST_D_LD:
            begin
                cmd.op     = OP_M_LATCH;
                state_next = ST_D_MUL;
            end
            ST_D_MUL:
            begin
                cmd.op     = OP_DET_MUL;
                state_next = ST_D_ACC;
            end
            ST_D_ACC:
            begin
                cmd.op = OP_DET_ACC;
                if (chunk_reg == CHUNK_IDX_W'(N_CHUNK - 1))
                begin
                    cof_next   = cof_reg + IDX_W'(1);
                    term_next  = '0;
                    state_next = ST_T_AX;
                end
                else
                begin
                    chunk_next = chunk_reg + CHUNK_IDX_W'(1);
                    state_next = ST_D_MUL;
                end
            end
            ST_D_CHK:
            begin
                cmd.op     = OP_DET_CHK;
                emit_next  = '0;
                state_next = ST_E_SEL;
            end
            ST_E_SEL:
            begin
                state_next = status.det_zero ? ST_S_RD : ST_V_RD;
            end
            ST_S_RD:
            begin
                cmd.mat_addr = emit_reg;
                state_next   = ST_S_OUT;
            end
            ST_S_OUT:
            begin
                cmd.op = OP_EMIT;
                if (last_emit)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    emit_next  = emit_reg + IDX_W'(1);
                    state_next = ST_S_RD;
                end
            end
            ST_V_RD:
            begin
                cmd.cof_addr = emit_reg;
                state_next   = ST_V_LD;
            end
            ST_V_LD:
            begin
                cmd.op     = OP_DIV_LD;
                step_next  = '0;
                state_next = ST_V_IT;
            end
            ST_V_IT:
            begin
                cmd.op = OP_DIV_STEP;
                if (step_reg == STEP_W'(ELEM_WIDTH))
                begin
                    state_next = ST_V_OUT;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_V_OUT:
            begin
                cmd.op = OP_EMIT;
                if (last_emit)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    emit_next  = emit_reg + IDX_W'(1);
                    state_next = ST_V_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cof_reg    <= '0;
            term_reg   <= '0;
            chunk_reg  <= '0;
            emit_reg   <= '0;
            step_reg   <= '0;
            busy_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cof_reg    <= cof_next;
            term_reg   <= term_next;
            chunk_reg  <= chunk_next;
            emit_reg   <= emit_next;
            step_reg   <= step_next;
            busy_reg   <= (state_next != ST_IDLE);
            strobe_reg <= (state_reg == ST_S_OUT) || (state_reg == ST_V_OUT);
        end
    end

    assign busy          = busy_reg;
    assign result_strobe = strobe_reg;

endmodule
`default_nettype wire

/* design/matrix4_cofactor_inverse.sv */
// 4x4 matrix inverse by cofactors, signed fixed point. A load item writes one
// element; busy stays low. An invert item raises busy and computes the
// sixteen cofactors and the determinant exactly through one shared 33x33
// multiplier, then divides each cofactor by the determinant in a bit-serial
// divider of ELEM_WIDTH+1 steps. The sixteen result items leave one per
// strobe in index order with no way to hold them off; the receiver must take
// each item in the cycle it is shown. The last strobe may coincide with the
// acceptance of the next item.
`default_nettype none
module matrix4_cofactor_inverse import m4ci_pkg::*; #(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire item_t item,
    output logic       result_strobe,
    output result_t    result
);

    dp_cmd_t    cmd;
    dp_status_t status;

    m4ci_ctrl #(.ELEM_WIDTH(ELEM_WIDTH)) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .item          (item),
        .status        (status),
        .cmd           (cmd),
        .busy          (busy),
        .result_strobe (result_strobe)
    );

    m4ci_dp #(.FRAC_BITS(FRAC_BITS), .ELEM_WIDTH(ELEM_WIDTH)) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !result.last_element |-> busy)
        else $error("busy low before last item");

    a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |=> !result_strobe)
        else $error("adjacent result strobes");

    a_invert_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (item.action == ACT_INVERT) |=> busy)
        else $error("invert item did not raise busy");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (item.action == ACT_LOAD) |=> !busy && !result_strobe)
        else $error("load item caused activity");

endmodule
`default_nettype wire

/* verif/m4ci_checker.sv */
`timescale 1ns / 100ps
module m4ci_checker import m4ci_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire logic    busy,
    input  wire item_t   item,
    input  wire logic    result_strobe,
    input  wire result_t result,
    output int           pending,
    output int           fail_count,
    output logic         accepted
);

    typedef logic signed [191:0] wide_t;

    logic signed [31:0] matrix_shadow [N_ELEM];
    result_t            inverse_q [$];

    function automatic wide_t minor3(int skip_row, int skip_col);
        wide_t e [3][3];
        int    nr;
        int    nc;
        nr = 0;
        for (int r = 0; r < 4; r++)
        begin
            if (r != skip_row)
            begin
                nc = 0;
                for (int c = 0; c < 4; c++)
                begin
                    if (c != skip_col)
                    begin
                        e[nr][nc] = wide_t'(matrix_shadow[r * 4 + c]);
                        nc++;
                    end
                end
                nr++;
            end
        end
        return e[0][0] * (e[1][1] * e[2][2] - e[1][2] * e[2][1])
             - e[0][1] * (e[1][0] * e[2][2] - e[1][2] * e[2][0])
             + e[0][2] * (e[1][0] * e[2][1] - e[1][1] * e[2][0]);
    endfunction

    task automatic predict_inverse();
        wide_t   cof [N_ELEM];
        wide_t   det;
        wide_t   quot;
        result_t res;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                cof[r * 4 + c] = ((r + c) % 2 == 1) ? -minor3(c, r) : minor3(c, r);
            end
        end
        det = '0;
        for (int c = 0; c < 4; c++)
        begin
            det = det + cof[c * 4] * wide_t'(matrix_shadow[c]);
        end
        for (int k = 0; k < N_ELEM; k++)
        begin
            res.out_index    = IDX_W'(k);
            res.singular     = (det == 0);
            res.last_element = (k == N_ELEM - 1);
            if (det == 0)
            begin
                res.out_value = matrix_shadow[k];
            end
            else
            begin
                quot = (cof[k] <<< 32) / det;
                if (quot > wide_t'(32'sh7fffffff))
                    quot = wide_t'(32'sh7fffffff);
                else if (quot < wide_t'(-33'sh80000000))
                    quot = wide_t'(-33'sh80000000);
                res.out_value = quot[31:0];
            end
            inverse_q.push_back(res);
        end
    endtask

    assign pending  = inverse_q.size();
    assign accepted = (start && !busy) || result_strobe;

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_res;
        if (!rst_n)
        begin
            for (int i = 0; i < N_ELEM; i++)
                matrix_shadow[i] = '0;
            inverse_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (result_strobe)
            begin
                if (inverse_q.size() == 0)
                begin
                    $error("unexpected result index %0d value %h",
                           result.out_index, result.out_value);
                    fail_count++;
                end
                else
                begin
                    exp_res = inverse_q.pop_front();
                    if (result.out_index !== exp_res.out_index)
                    begin
                        $error("out_index: expected %0d, got %0d",
                               exp_res.out_index, result.out_index);
                        fail_count++;
                    end
                    if (result.out_value !== exp_res.out_value)
                    begin
                        $error("out_value[%0d]: expected %h, got %h",
                               exp_res.out_index, exp_res.out_value, result.out_value);
                        fail_count++;
                    end
                    if (result.singular !== exp_res.singular)
                    begin
                        $error("singular: expected %b, got %b",
                               exp_res.singular, result.singular);
                        fail_count++;
                    end
                    if (result.last_element !== exp_res.last_element)
                    begin
                        $error("last_element: expected %b, got %b",
                               exp_res.last_element, result.last_element);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                if (item.action == ACT_LOAD)
                    matrix_shadow[item.element_index] = item.element_value;
                else
                    predict_inverse();
            end
        end
    end

endmodule

/* verif/tb_matrix4_cofactor_inverse.sv */
`timescale 1ns / 100ps
module tb_matrix4_cofactor_inverse;
    import m4ci_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    result_strobe;
    result_t result;
    int      pending;
    int      fail_count;
    logic    accepted;
    int      idle_pct;
    int      quiet_cycles;

    matrix4_cofactor_inverse i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .result_strobe (result_strobe),
        .result        (result)
    );

    m4ci_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .result_strobe (result_strobe),
        .result        (result),
        .pending       (pending),
        .fail_count    (fail_count),
        .accepted      (accepted)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        if (!rst_n || accepted)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send(input logic act, input logic [3:0] idx, input logic [31:0] val);
        int gap;
        start              <= 1'b1;
        item.action        <= act;
        item.element_index <= idx;
        item.element_value <= val;
        do
            @(posedge clk);
        while (busy);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] rand_value(int mode);
        case (mode)
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
            2:       return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return $urandom_range(1) ? 32'h00000001 : 32'hffffffff;
        endcase
    endfunction

    task automatic load_matrix(input int mode);
        int dup_row;
        logic [31:0] row_vals [4];
        dup_row = $urandom_range(9);
        for (int c = 0; c < 4; c++)
            row_vals[c] = rand_value(mode);
        for (int k = 0; k < N_ELEM; k++)
        begin
            if (dup_row < 4 && (k / 4 == dup_row || k / 4 == (dup_row + 1) % 4))
                send(ACT_LOAD, 4'(k), row_vals[k % 4]);
            else if ($urandom_range(9) == 0)
                send(ACT_LOAD, 4'(k), rand_value($urandom_range(3)));
            else
                send(ACT_LOAD, 4'(k), rand_value(mode));
        end
    endtask

    task automatic run_phase(input int pct, input int n_seq);
        idle_pct = pct;
        for (int s = 0; s < n_seq; s++)
        begin
            if ($urandom_range(4) == 0)
                send(ACT_LOAD, 4'($urandom), $urandom);
            else
                load_matrix($urandom_range(3) == 0 ? 0 : $urandom_range(1, 3) % 2);
            send(ACT_INVERT, 4'($urandom), $urandom);
            if (s == n_seq / 2)
            begin
                start <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        item         = '0;
        idle_pct     = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(ACT_INVERT, 4'hf, 32'hffffffff);
        for (int k = 0; k < N_ELEM; k++)
            send(ACT_LOAD, 4'(k), (k % 5 == 0) ? 32'h00010000 : 32'h0);
        send(ACT_INVERT, 4'h0, 32'h0);
        send(ACT_LOAD, 4'h0, 32'h00000001);
        send(ACT_LOAD, 4'h5, 32'hffffffff);
        send(ACT_INVERT, 4'h5, 32'h0);
        send(ACT_LOAD, 4'ha, 32'h7fffffff);
        send(ACT_LOAD, 4'hf, 32'h80000000);
        send(ACT_INVERT, 4'ha, 32'h12345678);
        send(ACT_LOAD, 4'h3, 32'h80000000);
        send(ACT_INVERT, 4'h3, 32'h0);

        run_phase(0, 8);
        run_phase(70, 8);
        run_phase(38, 8);
        idle_pct = 0;
        run_phase(0, 6);

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
